### sv/ndsb_pkg.sv
// Shared types and constants for the NFA to DFA subset builder.
// No dependencies; used by the controller, datapath and top level.
package ndsb_pkg;
  localparam int MASK_W = 6;
  localparam int ROW_W  = 19;

  typedef struct packed {
    logic clos_start;   // begin closure pass
    logic clos_step;    // one closure iteration
    logic seed;         // store the start subset
    logic step_sym;     // 0: symbol zero, 1: symbol one
    logic move;         // compute a move and look up
    logic commit;       // record the transition row
    logic emit;         // read a transition row for output
  } ctl_cmd_t;

  typedef struct packed {
    logic clos_done;
    logic find_done;
    logic work_done;
  } ctl_sts_t;
endpackage

### sv/ndsb_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module ndsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/ndsb_datapath.sv
// Datapath of the subset builder: NFA rows, closures, subset search, DFA rows.
// Depends on ndsb_pkg and ndsb_ram.
module ndsb_datapath import ndsb_pkg::*; #(
  parameter int NFA_STATES = 6,
  parameter int DFA_STATES = 64,
  localparam int DW = $clog2(DFA_STATES),
  localparam int CW = $clog2(DFA_STATES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_we,
  input  logic [2:0]     load_idx,
  input  logic [ROW_W-1:0] load_row,
  input  logic [2:0]     states_in_use,
  input  ctl_cmd_t       cmd,
  output ctl_sts_t       sts,
  output logic [DW-1:0]  emit_idx,
  output logic [CW-1:0]  count,
  output logic [12:0]    emit_row
);
  logic [ROW_W-1:0]  rows_r [NFA_STATES];
  logic [MASK_W-1:0] clos_r [NFA_STATES];
  logic [MASK_W-1:0] clos_nxt [NFA_STATES];
  logic [MASK_W-1:0] am;
  logic [2:0]        n_act;

  always_comb begin
    n_act = states_in_use;
    if (n_act == 3'd0) n_act = 3'd1;
    if (32'(n_act) > NFA_STATES) n_act = 3'(NFA_STATES);
    am = MASK_W'((7'd1 << n_act) - 7'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NFA_STATES; i++) rows_r[i] <= '0;
    end else if (load_we && 32'(load_idx) < NFA_STATES) begin
      rows_r[load_idx] <= load_row;
    end
  end

  // One closure iteration: every state's set absorbs the epsilon targets of its members.
  logic clos_chg;
  always_comb begin
    clos_chg = 1'b0;
    for (int i = 0; i < NFA_STATES; i++) begin
      clos_nxt[i] = clos_r[i];
      for (int j = 0; j < NFA_STATES; j++)
        if (clos_r[i][j]) clos_nxt[i] = clos_nxt[i] | (rows_r[j][5:0] & am);
      clos_nxt[i] = clos_nxt[i] & am;
      if (clos_nxt[i] != clos_r[i]) clos_chg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NFA_STATES; i++) begin
      if (cmd.clos_start) clos_r[i] <= (i < 32'(n_act)) ? (rows_r[i][5:0] & am) : '0;
      else if (cmd.clos_step) clos_r[i] <= clos_nxt[i];
    end
  end

  // Current subset being processed, its move, and the search over known subsets.
  logic [CW-1:0]     built_r, work_r, scan_r;
  logic [MASK_W-1:0] cur_r, tgt_r;
  logic [MASK_W-1:0] sub_q;
  logic              scan_act_r, scan_rd_r, acc_r;
  logic [DW-1:0]     z_r;
  logic [DW-1:0]     res_idx;
  logic              found;
  logic              find_done;
  logic              sub_we;
  logic [DW-1:0]     sub_wa, sub_ra;
  logic [MASK_W-1:0] sub_wd;

  logic [MASK_W-1:0] mv_t, mv_r;
  logic              mv_acc;
  always_comb begin
    mv_t = '0;
    mv_acc = 1'b0;
    for (int j = 0; j < NFA_STATES; j++) if (cur_r[j]) begin
      mv_t = mv_t | ((cmd.step_sym ? rows_r[j][11:6] : rows_r[j][17:12]) & am);
      mv_acc = mv_acc | rows_r[j][18];
    end
    mv_r = mv_t;
    for (int j = 0; j < NFA_STATES; j++) if (mv_t[j]) mv_r = mv_r | clos_r[j];
    mv_r = mv_r & am;
  end

  // Scan: read address scan_r, compare its data in the next cycle.
  assign found = scan_rd_r && (sub_q == tgt_r);
  assign sub_ra = scan_act_r ? DW'(scan_r) : DW'(work_r);
  logic [CW-1:0] scan_prev_r;

  always_comb begin
    sub_we = 1'b0;
    sub_wa = DW'(built_r);
    sub_wd = tgt_r;
    res_idx = DW'(scan_prev_r);
    find_done = 1'b0;
    if (scan_act_r) begin
      if (found) begin
        find_done = 1'b1;
      end else if (!scan_rd_r && scan_r >= built_r) begin
        find_done = 1'b1;
        if (32'(built_r) < DFA_STATES) begin
          sub_we = 1'b1;
          res_idx = DW'(built_r);
        end else begin
          res_idx = DW'(DFA_STATES - 1);
        end
      end
    end
    if (cmd.seed) begin
      sub_we = 1'b1;
      sub_wa = '0;
      sub_wd = (MASK_W'(1) | clos_r[0]) & am;
    end
  end

  ndsb_ram #(.WIDTH(MASK_W), .DEPTH(DFA_STATES)) u_sub (
    .clk(clk), .we(sub_we), .waddr(sub_wa), .wdata(sub_wd),
    .raddr(sub_ra), .rdata(sub_q));

  // The next subset's address settles in the cycle after seed or commit, and its
  // registered read data arrives in the cycle after that.
  logic cur_wait_r, cur_fill_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      built_r <= '0; work_r <= '0; scan_act_r <= 1'b0; scan_rd_r <= 1'b0;
      cur_wait_r <= 1'b0; cur_fill_r <= 1'b0;
    end else begin
      cur_wait_r <= 1'b0;
      cur_fill_r <= cur_wait_r;
      if (cmd.seed) begin
        built_r <= CW'(1); work_r <= '0; cur_wait_r <= 1'b1;
      end
      if (cur_fill_r) cur_r <= sub_q;
      if (cmd.move) begin
        tgt_r <= mv_r; acc_r <= mv_acc; scan_act_r <= 1'b1;
        scan_r <= '0; scan_rd_r <= 1'b0;
      end else if (scan_act_r) begin
        if (find_done) begin
          scan_act_r <= 1'b0; scan_rd_r <= 1'b0;
          if (sub_we) built_r <= built_r + CW'(1);
          if (!cmd.step_sym) z_r <= res_idx;
        end else if (scan_r < built_r) begin
          scan_prev_r <= scan_r; scan_r <= scan_r + CW'(1); scan_rd_r <= 1'b1;
        end else begin
          scan_rd_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        work_r <= work_r + CW'(1); cur_wait_r <= 1'b1;
      end
    end
  end

  assign sts = '{clos_done: !clos_chg, find_done: find_done, work_done: (work_r >= built_r)};

  logic [DW-1:0] one_r;
  always_ff @(posedge clk) if (scan_act_r && find_done && cmd.step_sym) one_r <= res_idx;

  ndsb_ram #(.WIDTH(13), .DEPTH(DFA_STATES)) u_trn (
    .clk(clk), .we(cmd.commit), .waddr(DW'(work_r)),
    .wdata({acc_r, 6'(z_r), 6'(one_r)}),
    .raddr(emit_idx), .rdata(emit_row));

  logic [DW-1:0] emit_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.seed) emit_r <= '0;
    else if (cmd.emit) emit_r <= emit_r + DW'(1);
  end
  assign emit_idx = emit_r;
  assign count = built_r;
endmodule

### sv/ndsb_ctrl.sv
// Controller state machine of the subset builder.
// Depends on ndsb_pkg; drives the datapath by command struct.
module ndsb_ctrl import ndsb_pkg::*; #(
  parameter int DFA_STATES = 64,
  localparam int DW = $clog2(DFA_STATES),
  localparam int CW = $clog2(DFA_STATES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          build_go,
  output logic          busy,
  input  ctl_sts_t      sts,
  output ctl_cmd_t      cmd,
  input  logic [DW-1:0] emit_idx,
  input  logic [CW-1:0] count,
  output logic          out_load,
  output logic          out_last,
  input  logic          out_free
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CLOS = 4'd1, S_SEED = 4'd2, S_WAIT = 4'd3,
    S_MV0 = 4'd4, S_FD0 = 4'd5, S_MV1 = 4'd6, S_FD1 = 4'd7, S_CMT = 4'd8,
    S_RD = 4'd9, S_OUT = 4'd10, S_GAP = 4'd11;
  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_load = 1'b0;
    out_last = 1'b0;
    case (state_r)
      S_IDLE: if (build_go) begin cmd.clos_start = 1'b1; state_nxt = S_CLOS; end
      S_CLOS: begin
        cmd.clos_step = 1'b1;
        if (sts.clos_done) state_nxt = S_SEED;
      end
      S_SEED: begin cmd.seed = 1'b1; state_nxt = S_GAP; end
      S_GAP:  state_nxt = S_WAIT;
      S_WAIT: state_nxt = sts.work_done ? S_RD : S_MV0;
      S_MV0:  begin cmd.move = 1'b1; state_nxt = S_FD0; end
      S_FD0:  if (sts.find_done) state_nxt = S_MV1;
      S_MV1:  begin cmd.move = 1'b1; cmd.step_sym = 1'b1; state_nxt = S_FD1; end
      S_FD1:  begin cmd.step_sym = 1'b1; if (sts.find_done) state_nxt = S_CMT; end
      S_CMT:  begin cmd.commit = 1'b1; state_nxt = S_GAP; end
      S_RD:   state_nxt = S_OUT;
      S_OUT: if (out_free) begin
        out_load = 1'b1;
        out_last = (CW'(emit_idx) + CW'(1) == count);
        cmd.emit = 1'b1;
        state_nxt = out_last ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
  assign busy = (state_r != S_IDLE);
endmodule

### sv/nfa_to_dfa_subset_builder.sv
// Top level of the NFA to DFA subset builder; uses ndsb_pkg, ndsb_ctrl, ndsb_datapath, ndsb_ram.
// Operation: a load word stores one NFA row and gives no result. A build word iterates the
// closures until no set changes, then per DFA state runs two moves, each a search over the
// subsets found so far, then emits the rows in order, waiting while the output register is full.
// Throughput: one load word per cycle while idle; input is held off for the whole build.
// Reset (rst_n low, synchronous) clears rows, count and control, and sets states_in_use to 6.
module nfa_to_dfa_subset_builder import ndsb_pkg::*; #(
  parameter int NFA_STATES = 6,
  parameter int DFA_STATES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row_index, row_accepting, on_zero, on_one, on_empty
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // dfa_state, dfa_accepting, next_on_zero, next_on_one,
                                  // dfa_count
  output logic        out_tlast,  // last_row
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  localparam int DW = $clog2(DFA_STATES);
  localparam int CW = $clog2(DFA_STATES + 1);

  logic [2:0] siu_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) siu_r <= 3'd6;
    else if (cfg_valid) siu_r <= cfg_data;
  end

  logic busy, acc;
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic [DW-1:0] emit_idx;
  logic [CW-1:0] count;
  logic [12:0] emit_row;
  logic out_load, out_last;

  // Output register: the controller waits until it is free.
  logic ov_r;
  logic out_free;
  assign out_free = !ov_r || out_tready;
  assign in_tready = !busy;
  assign acc = in_tvalid && in_tready;

  ndsb_ctrl #(.DFA_STATES(DFA_STATES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .build_go(acc && in_tuser), .busy(busy),
    .sts(sts), .cmd(cmd), .emit_idx(emit_idx), .count(count),
    .out_load(out_load), .out_last(out_last), .out_free(out_free));

  ndsb_datapath #(.NFA_STATES(NFA_STATES), .DFA_STATES(DFA_STATES)) u_dp (
    .clk(clk), .rst_n(rst_n), .load_we(acc && !in_tuser), .load_idx(in_tdata[2:0]),
    .load_row({in_tdata[3], in_tdata[9:4], in_tdata[15:10], in_tdata[21:16]}),
    .states_in_use(siu_r), .cmd(cmd), .sts(sts), .emit_idx(emit_idx),
    .count(count), .emit_row(emit_row));

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (out_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (out_load) begin
      out_tdata <= {6'd0, 7'(count), 6'(emit_row[5:0]), 6'(emit_row[11:6]), emit_row[12],
                    6'(emit_idx)};
      out_tlast <= out_last;
    end
  end
  assign out_tvalid = ov_r;
endmodule

### sv/ndsb_checker.sv
// Port-level checker for the subset builder, bound to the top level.
// No package dependencies.
module ndsb_checker (
  input logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready, out_tlast,
  input logic [31:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:19] != 7'd0) else $error("count");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[5:0] + 7'd1 == out_tdata[25:19]) else $error("last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready) else $error("busy");
endmodule

bind nfa_to_dfa_subset_builder ndsb_checker u_chk (.*);
